// ===== design/ctxq_pkg.sv =====
`default_nettype none

package ctxq_pkg;

	localparam int QDEPTH = 64;
	localparam int PTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W  = $clog2(QDEPTH + 1);

	localparam int MAX_LEN   = 8;
	localparam int BACKOFF_W = 17;

	// input actions
	localparam logic [1:0] ACT_PUSH  = 2'd0;
	localparam logic [1:0] ACT_TICK  = 2'd1;
	localparam logic [1:0] ACT_FLUSH = 2'd2;

	// link outcomes
	localparam logic [1:0] OUTC_SENT = 2'd0;
	localparam logic [1:0] OUTC_BUSY = 2'd1;

	// result status codes
	localparam logic [3:0] STAT_QUEUED   = 4'd0;
	localparam logic [3:0] STAT_NOT_OPEN = 4'd1;
	localparam logic [3:0] STAT_TOO_LONG = 4'd2;
	localparam logic [3:0] STAT_FULL     = 4'd3;
	localparam logic [3:0] STAT_IDLE     = 4'd4;
	localparam logic [3:0] STAT_BACKOFF  = 4'd5;
	localparam logic [3:0] STAT_SENT     = 4'd6;
	localparam logic [3:0] STAT_BUSY     = 4'd7;
	localparam logic [3:0] STAT_DROPPED  = 4'd8;
	localparam logic [3:0] STAT_FLUSHED  = 4'd9;

	// configuration register indexes
	localparam logic [1:0] REG_LINK_OPEN = 2'd0;
	localparam logic [1:0] REG_TICK_INTV = 2'd1;
	localparam logic [1:0] REG_BO_BASE   = 2'd2;
	localparam logic [1:0] REG_BO_MAXSH  = 2'd3;

	typedef struct packed {
		logic       push;
		logic       flush;
		logic       dec;
		logic       capture;
		logic       sent;
		logic       busy;
		logic       drop;
		logic       load;
		logic       present;
		logic [3:0] status;
	} cmd_t;

	typedef struct packed {
		logic       link_open;
		logic       full;
		logic       empty;
		logic       backoff_pend;
		logic       len_bad;
		logic [1:0] outcome;
	} stat_t;

endpackage

`default_nettype wire

// ===== design/can_tx_queue_with_backoff.sv =====
`default_nettype none

// transmit frame queue with exponential backoff, 64 frames deep. a push, a flush, an idle
// tick or a backoff countdown tick produces its result in the cycle after it is accepted;
// a tick that presents the head frame passes through the EXEC state first, because the
// frame memory read is registered. the block works on one item at a time and takes the
// next item once its result register is empty or being drained in the same cycle, so a
// steady stream runs at one item per cycle except during EXEC. configuration writes are always
// accepted (cfg_ready is tied high) and are meant to be issued while no item is in flight.
// the frame memory has no reset and no clearing pass; only entries that were pushed are read
module can_tx_queue_with_backoff (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [1:0]  action,
	input  wire  [28:0] frame_id,
	input  wire         extended,
	input  wire         remote,
	input  wire  [3:0]  payload_len,
	input  wire  [63:0] payload_bytes,
	input  wire  [1:0]  link_outcome,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [3:0]  status,
	output logic        tx_valid,
	output logic [31:0] tx_word,
	output logic [3:0]  tx_len,
	output logic [63:0] tx_data,
	output logic [16:0] backoff_left,
	output logic [6:0]  queue_level,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [9:0]  cfg_data
);
	import ctxq_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	ctxq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.action    (action),
		.stat      (stat),
		.cmd       (cmd)
	);

	ctxq_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.frame_id      (frame_id),
		.extended      (extended),
		.remote        (remote),
		.payload_len   (payload_len),
		.payload_bytes (payload_bytes),
		.link_outcome  (link_outcome),
		.status        (status),
		.tx_valid      (tx_valid),
		.tx_word       (tx_word),
		.tx_len        (tx_len),
		.tx_data       (tx_data),
		.backoff_left  (backoff_left),
		.queue_level   (queue_level)
	);

endmodule

`default_nettype wire

// ===== design/ctxq_ctrl.sv =====
`default_nettype none

module ctxq_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire                out_ready,
	input  wire  [1:0]         action,
	input  ctxq_pkg::stat_t    stat,
	output ctxq_pkg::cmd_t     cmd
);
	import ctxq_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic state_d;
	logic out_valid_q;
	logic accept;

	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		cmd.status = STAT_IDLE;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (action)
						ACT_PUSH: begin
							cmd.load = 1'b1;
							if (!stat.link_open) begin
								cmd.status = STAT_NOT_OPEN;
							end else if (stat.len_bad) begin
								cmd.status = STAT_TOO_LONG;
							end else if (stat.full) begin
								cmd.status = STAT_FULL;
							end else begin
								cmd.status = STAT_QUEUED;
								cmd.push   = 1'b1;
							end
						end
						ACT_TICK: begin
							if (!stat.link_open || stat.empty) begin
								cmd.load   = 1'b1;
								cmd.status = STAT_IDLE;
							end else if (stat.backoff_pend) begin
								cmd.load   = 1'b1;
								cmd.dec    = 1'b1;
								cmd.status = STAT_BACKOFF;
							end else begin
								// head frame read is registered, finish next cycle
								cmd.capture = 1'b1;
								state_d     = ST_EXEC;
							end
						end
						ACT_FLUSH: begin
							cmd.load   = 1'b1;
							cmd.flush  = 1'b1;
							cmd.status = STAT_FLUSHED;
						end
						default: begin
							cmd.load   = 1'b1;
							cmd.status = STAT_IDLE;
						end
					endcase
				end
			end
			ST_EXEC: begin
				cmd.load    = 1'b1;
				cmd.present = 1'b1;
				state_d     = ST_IDLE;
				case (stat.outcome)
					OUTC_SENT: begin
						cmd.sent   = 1'b1;
						cmd.status = STAT_SENT;
					end
					OUTC_BUSY: begin
						cmd.busy   = 1'b1;
						cmd.status = STAT_BUSY;
					end
					default: begin
						cmd.drop   = 1'b1;
						cmd.status = STAT_DROPPED;
					end
				endcase
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/ctxq_dp.sv =====
`default_nettype none

module ctxq_dp (
	input  wire                clk,
	input  wire                arst_n,
	input  ctxq_pkg::cmd_t     cmd,
	output ctxq_pkg::stat_t    stat,
	input  wire                cfg_we,
	input  wire  [1:0]         cfg_index,
	input  wire  [9:0]         cfg_data,
	input  wire  [28:0]        frame_id,
	input  wire                extended,
	input  wire                remote,
	input  wire  [3:0]         payload_len,
	input  wire  [63:0]        payload_bytes,
	input  wire  [1:0]         link_outcome,
	output logic [3:0]         status,
	output logic               tx_valid,
	output logic [31:0]        tx_word,
	output logic [3:0]         tx_len,
	output logic [63:0]        tx_data,
	output logic [16:0]        backoff_left,
	output logic [6:0]         queue_level
);
	import ctxq_pkg::*;

	// configuration
	logic       link_open_q;
	logic [9:0] tick_intv_q;
	logic [9:0] bo_base_q;
	logic [2:0] bo_maxsh_q;

	// queue and backoff state
	logic [PTR_W-1:0]     rp_q, rp_d;
	logic [PTR_W-1:0]     wp_q, wp_d;
	logic [CNT_W-1:0]     cnt_q, cnt_d;
	logic [BACKOFF_W-1:0] bo_q, bo_d;
	logic [2:0]           sh_q, sh_d;
	logic [1:0]           outcome_q;

	// frame memory
	logic [35:0] hdr_mem [QDEPTH];
	logic [63:0] pay_mem [QDEPTH];
	logic [35:0] rd_hdr_q;
	logic [63:0] rd_pay_q;

	logic [63:0] pay_masked;
	logic [35:0] hdr_new;

	// result register
	logic [3:0]  status_q;
	logic        tx_valid_q;
	logic [31:0] tx_word_q;
	logic [3:0]  tx_len_q;
	logic [63:0] tx_data_q;
	logic [16:0] bo_left_q;
	logic [6:0]  level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_open_q <= 1'b0;
			tick_intv_q <= 10'd10;
			bo_base_q   <= 10'd10;
			bo_maxsh_q  <= 3'd5;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LINK_OPEN: link_open_q <= cfg_data[0];
				REG_TICK_INTV: tick_intv_q <= cfg_data;
				REG_BO_BASE:   bo_base_q   <= cfg_data;
				REG_BO_MAXSH:  bo_maxsh_q  <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// bytes at and above the length are stored as zero
	always_comb begin
		for (int i = 0; i < MAX_LEN; i++) begin
			pay_masked[i*8 +: 8] = (4'(i) < payload_len) ? payload_bytes[i*8 +: 8] : 8'h00;
		end
	end

	assign hdr_new = {payload_len, extended, remote, 1'b0, frame_id};

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_comb begin
		rp_d  = rp_q;
		wp_d  = wp_q;
		cnt_d = cnt_q;
		bo_d  = bo_q;
		sh_d  = sh_q;
		if (cmd.flush) begin
			rp_d  = '0;
			wp_d  = '0;
			cnt_d = '0;
			bo_d  = '0;
			sh_d  = '0;
		end
		if (cmd.push) begin
			wp_d  = ptr_inc(wp_q);
			cnt_d = cnt_q + 1'b1;
		end
		if (cmd.dec) begin
			bo_d = (bo_q > BACKOFF_W'(tick_intv_q)) ? bo_q - BACKOFF_W'(tick_intv_q) : '0;
		end
		if (cmd.sent || cmd.drop) begin
			rp_d  = ptr_inc(rp_q);
			cnt_d = cnt_q - 1'b1;
		end
		if (cmd.sent) begin
			sh_d = '0;
		end
		if (cmd.busy) begin
			bo_d = BACKOFF_W'(bo_base_q) << sh_q;
			if (sh_q < bo_maxsh_q) begin
				sh_d = sh_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q  <= '0;
			wp_q  <= '0;
			cnt_q <= '0;
			bo_q  <= '0;
			sh_q  <= '0;
		end else begin
			rp_q  <= rp_d;
			wp_q  <= wp_d;
			cnt_q <= cnt_d;
			bo_q  <= bo_d;
			sh_q  <= sh_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			hdr_mem[wp_q] <= hdr_new;
			pay_mem[wp_q] <= pay_masked;
		end
		rd_hdr_q <= hdr_mem[rp_q];
		rd_pay_q <= pay_mem[rp_q];
		if (cmd.capture) begin
			outcome_q <= link_outcome;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status_q   <= cmd.status;
			tx_valid_q <= cmd.present;
			tx_word_q  <= cmd.present ? rd_hdr_q[31:0] : '0;
			tx_len_q   <= cmd.present ? rd_hdr_q[35:32] : '0;
			tx_data_q  <= cmd.present ? rd_pay_q : '0;
			bo_left_q  <= bo_d;
			level_q    <= 7'(cnt_d);
		end
	end

	assign stat.link_open    = link_open_q;
	assign stat.full         = (cnt_q == CNT_W'(QDEPTH));
	assign stat.empty        = (cnt_q == '0);
	assign stat.backoff_pend = (bo_q != '0);
	assign stat.len_bad      = (payload_len > 4'(MAX_LEN));
	assign stat.outcome      = outcome_q;

	assign status       = status_q;
	assign tx_valid     = tx_valid_q;
	assign tx_word      = tx_word_q;
	assign tx_len       = tx_len_q;
	assign tx_data      = tx_data_q;
	assign backoff_left = bo_left_q;
	assign queue_level  = level_q;

endmodule

`default_nettype wire

// ===== design/ctxq_checker.sv =====
`default_nettype none

module ctxq_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        out_valid,
	input wire        out_ready,
	input wire [3:0]  status,
	input wire        tx_valid,
	input wire [31:0] tx_word,
	input wire [3:0]  tx_len,
	input wire [63:0] tx_data,
	input wire [16:0] backoff_left,
	input wire [6:0]  queue_level
);
	import ctxq_pkg::*;

	// a waiting result transaction is not withdrawn
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before it was taken");

	// a presented frame always comes from a transmit attempt and carries a legal length
	a_present: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tx_valid |-> (tx_len <= 4'd8) &&
			(status == STAT_SENT || status == STAT_BUSY || status == STAT_DROPPED))
		else $error("presented frame with bad status or length");

	// frame fields are zero when nothing is presented
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !tx_valid |-> tx_word == '0 && tx_len == '0 && tx_data == '0)
		else $error("frame fields nonzero without a presented frame");

	// flush leaves an empty queue and no backoff
	a_flush: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_FLUSHED |-> queue_level == '0 && backoff_left == '0)
		else $error("flush left frames or backoff behind");

endmodule

bind can_tx_queue_with_backoff ctxq_checker u_ctxq_checker (.*);

`default_nettype wire
